// ----- design/doc_comment_body_extractor_defines.svh -----
// Assertion macros shared by the doc comment body extractor modules.
// Needs nothing else; included by the files that carry assertions.
`ifndef DOC_COMMENT_BODY_EXTRACTOR_DEFINES_SVH
`define DOC_COMMENT_BODY_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define DCBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define DCBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dcbe_pkg.sv -----
// Shared types and constants of the doc comment body extractor.
// No dependencies; used by dcbe_dp, dcbe_ctrl and the top level.
`timescale 1ns / 1ps

package dcbe_pkg;

    localparam int DEF_MAX_INDENT      = 31;
    localparam int DEF_MAX_BLANK_LINES = 15;

    localparam int CH_W = 21;
    localparam int ST_W = 3;

    localparam logic [CH_W-1:0] CH_SLASH = 21'h00002F;
    localparam logic [CH_W-1:0] CH_STAR  = 21'h00002A;
    localparam logic [CH_W-1:0] CH_NL    = 21'h00000A;
    localparam logic [CH_W-1:0] CH_SP    = 21'h000020;
    localparam logic [CH_W-1:0] CH_TAB   = 21'h000009;
    localparam logic [CH_W-1:0] CH_CR    = 21'h00000D;
    localparam logic [CH_W-1:0] CH_NONE  = 21'h000000;

    localparam logic [ST_W-1:0] ST_RUNNING    = 3'd0;
    localparam logic [ST_W-1:0] ST_DONE       = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_START   = 3'd2;
    localparam logic [ST_W-1:0] ST_UNKNOWN    = 3'd3;
    localparam logic [ST_W-1:0] ST_SHORT_SL   = 3'd4;
    localparam logic [ST_W-1:0] ST_SHORT_STAR = 3'd5;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_CLR,
        CNT_ONE
    } t_cnt_op;

    typedef enum logic [1:0] {
        SEL_NL,
        SEL_SP,
        SEL_CH,
        SEL_NONE
    } t_emit_sel;

    typedef struct packed {
        logic            take;
        t_cnt_op         base_op;
        t_cnt_op         line_op;
        t_cnt_op         blank_op;
        logic            fin;
        logic [ST_W-1:0] fin_code;
        logic            emit_blanks;
        logic            emit_spaces;
        logic            emit_char;
        logic            load_out;
        t_emit_sel       sel;
        logic            last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_slash;
        logic is_star;
        logic is_nl;
        logic is_sp;
        logic is_ws;
        logic is_cr;
        logic line_lt_base;
        logic line_zero;
        logic nl_zero;
        logic nl_one;
        logic sp_zero;
        logic sp_one;
        logic job_ch;
    } t_dp_status;

endpackage

// ----- design/dcbe_dp.sv -----
// Datapath: indentation and blank-line counters, status, pending emission job
// and output register. Depends on dcbe_pkg; driven by dcbe_ctrl.
`timescale 1ns / 1ps

module dcbe_dp #(
    parameter int MAX_INDENT      = dcbe_pkg::DEF_MAX_INDENT,
    parameter int MAX_BLANK_LINES = dcbe_pkg::DEF_MAX_BLANK_LINES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [dcbe_pkg::CH_W-1:0]   i_ch,
    input  logic                        i_begin_req,
    input  dcbe_pkg::t_dp_cmd           i_cmd,
    output dcbe_pkg::t_dp_status        o_status,
    output logic [dcbe_pkg::CH_W-1:0]   o_out_char,
    output logic                        o_has_char,
    output logic [dcbe_pkg::ST_W-1:0]   o_out_status,
    output logic                        o_last
);

    localparam int IW = $clog2(MAX_INDENT + 1);
    localparam int BW = $clog2(MAX_BLANK_LINES + 1);
    localparam logic [IW-1:0] IND_MAX = IW'(MAX_INDENT);
    localparam logic [BW-1:0] BLK_MAX = BW'(MAX_BLANK_LINES);

    logic [IW-1:0]             r_base, n_base, eff_base;
    logic [IW-1:0]             r_line, n_line, eff_line;
    logic [BW-1:0]             r_blank, n_blank, eff_blank;
    logic [dcbe_pkg::ST_W-1:0] r_st, eff_st;
    logic [BW-1:0]             r_nl;
    logic [IW-1:0]             r_sp;
    logic                      r_jch;
    logic [dcbe_pkg::CH_W-1:0] r_jchar;
    logic [dcbe_pkg::CH_W-1:0] r_out_char;
    logic                      r_has_char;
    logic [dcbe_pkg::ST_W-1:0] r_out_st;
    logic                      r_last;

    // A restart request sees the counters and status at their reset values.
    assign eff_base  = i_begin_req ? '0 : r_base;
    assign eff_line  = i_begin_req ? '0 : r_line;
    assign eff_blank = i_begin_req ? '0 : r_blank;
    assign eff_st    = i_begin_req ? dcbe_pkg::ST_RUNNING : r_st;

    always_comb begin
        unique case (i_cmd.base_op)
            dcbe_pkg::CNT_INC:  n_base = (eff_base < IND_MAX) ? eff_base + 1'b1 : IND_MAX;
            dcbe_pkg::CNT_CLR:  n_base = '0;
            dcbe_pkg::CNT_ONE:  n_base = IW'(1);
            default:            n_base = eff_base;
        endcase
        unique case (i_cmd.line_op)
            dcbe_pkg::CNT_INC:  n_line = (eff_line < IND_MAX) ? eff_line + 1'b1 : IND_MAX;
            dcbe_pkg::CNT_CLR:  n_line = '0;
            dcbe_pkg::CNT_ONE:  n_line = IW'(1);
            default:            n_line = eff_line;
        endcase
        unique case (i_cmd.blank_op)
            dcbe_pkg::CNT_INC:  n_blank = (eff_blank < BLK_MAX) ? eff_blank + 1'b1 : BLK_MAX;
            dcbe_pkg::CNT_CLR:  n_blank = '0;
            dcbe_pkg::CNT_ONE:  n_blank = BW'(1);
            default:            n_blank = eff_blank;
        endcase
    end

    always_comb begin
        o_status.is_slash     = (i_ch == dcbe_pkg::CH_SLASH);
        o_status.is_star      = (i_ch == dcbe_pkg::CH_STAR);
        o_status.is_nl        = (i_ch == dcbe_pkg::CH_NL);
        o_status.is_sp        = (i_ch == dcbe_pkg::CH_SP);
        o_status.is_cr        = (i_ch == dcbe_pkg::CH_CR);
        o_status.is_ws        = (i_ch == dcbe_pkg::CH_SP) || (i_ch == dcbe_pkg::CH_NL) ||
                                (i_ch == dcbe_pkg::CH_TAB) || (i_ch == dcbe_pkg::CH_CR);
        o_status.line_lt_base = (eff_line < eff_base);
        o_status.line_zero    = (eff_line == '0);
        o_status.nl_zero      = (r_nl == '0);
        o_status.nl_one       = (r_nl == BW'(1));
        o_status.sp_zero      = (r_sp == '0);
        o_status.sp_one       = (r_sp == IW'(1));
        o_status.job_ch       = r_jch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_line  <= '0;
            r_blank <= '0;
            r_st    <= dcbe_pkg::ST_RUNNING;
            r_nl    <= '0;
            r_sp    <= '0;
            r_jch   <= 1'b0;
        end else if (i_cmd.take) begin
            r_base  <= n_base;
            r_line  <= n_line;
            r_blank <= n_blank;
            r_st    <= i_cmd.fin ? i_cmd.fin_code : eff_st;
            r_nl    <= i_cmd.emit_blanks ? eff_blank : '0;
            r_sp    <= i_cmd.emit_spaces ? eff_line - eff_base : '0;
            r_jch   <= i_cmd.emit_char;
        end else if (i_cmd.load_out) begin
            // Drain the job: blank lines first, then spaces, then the character.
            unique case (i_cmd.sel)
                dcbe_pkg::SEL_NL: r_nl  <= r_nl - 1'b1;
                dcbe_pkg::SEL_SP: r_sp  <= r_sp - 1'b1;
                dcbe_pkg::SEL_CH: r_jch <= 1'b0;
                default:          r_jch <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_jchar <= i_ch;
        end
        if (i_cmd.load_out) begin
            unique case (i_cmd.sel)
                dcbe_pkg::SEL_NL: r_out_char <= dcbe_pkg::CH_NL;
                dcbe_pkg::SEL_SP: r_out_char <= dcbe_pkg::CH_SP;
                dcbe_pkg::SEL_CH: r_out_char <= r_jchar;
                default:          r_out_char <= dcbe_pkg::CH_NONE;
            endcase
            r_has_char <= (i_cmd.sel != dcbe_pkg::SEL_NONE);
            r_out_st   <= r_st;
            r_last     <= i_cmd.last;
        end
    end

    assign o_out_char   = r_out_char;
    assign o_has_char   = r_has_char;
    assign o_out_status = r_out_st;
    assign o_last       = r_last;

endmodule

// ----- design/dcbe_ctrl.sv -----
// Controller: comment parser state machine and emission sequencer.
// Depends on dcbe_pkg and the assertion macros; commands dcbe_dp.
`timescale 1ns / 1ps
`include "doc_comment_body_extractor_defines.svh"

module dcbe_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_begin_req,
    output logic                   o_valid,
    input  logic                   i_ready,
    input  dcbe_pkg::t_dp_status   i_status,
    output dcbe_pkg::t_dp_cmd      o_cmd
);

    localparam logic [3:0] M_START     = 4'd0;
    localparam logic [3:0] M_START2    = 4'd1;
    localparam logic [3:0] M_DONE      = 4'd2;
    localparam logic [3:0] M_S_START   = 4'd3;
    localparam logic [3:0] M_S_INSIDE  = 4'd4;
    localparam logic [3:0] M_S_NEWLINE = 4'd5;
    localparam logic [3:0] M_S_HALF    = 4'd6;
    localparam logic [3:0] M_S_BEFORE  = 4'd7;
    localparam logic [3:0] M_M_START   = 4'd8;
    localparam logic [3:0] M_M_INSIDE  = 4'd9;
    localparam logic [3:0] M_M_NEWLINE = 4'd10;
    localparam logic [3:0] M_M_BEFORE  = 4'd11;

    logic [3:0] r_mode, n_mode, eff_mode;
    logic       r_busy;
    logic       r_out_valid;
    logic       take;
    logic       load_out;
    logic       emit_last;
    logic       do_before;
    logic [3:0] bef_nl_mode;
    logic [3:0] bef_in_mode;
    logic [dcbe_pkg::ST_W-1:0] bef_err;
    dcbe_pkg::t_emit_sel sel;
    dcbe_pkg::t_dp_cmd   cmd;

    assign eff_mode = i_begin_req ? M_START : r_mode;

    // Emission sequencer: one result per cycle while output register is free.
    assign load_out = r_busy && (!r_out_valid || i_ready);

    always_comb begin
        if (!i_status.nl_zero) begin
            sel       = dcbe_pkg::SEL_NL;
            emit_last = i_status.nl_one && i_status.sp_zero && !i_status.job_ch;
        end else if (!i_status.sp_zero) begin
            sel       = dcbe_pkg::SEL_SP;
            emit_last = i_status.sp_one && !i_status.job_ch;
        end else if (i_status.job_ch) begin
            sel       = dcbe_pkg::SEL_CH;
            emit_last = 1'b1;
        end else begin
            sel       = dcbe_pkg::SEL_NONE;
            emit_last = 1'b1;
        end
    end

    assign o_ready = !r_busy || (load_out && emit_last);
    assign take    = i_valid && o_ready;

    // Parser decisions for the request at the inputs.
    always_comb begin
        n_mode      = eff_mode;
        cmd         = '0;
        cmd.base_op = dcbe_pkg::CNT_HOLD;
        cmd.line_op = dcbe_pkg::CNT_HOLD;
        cmd.blank_op = dcbe_pkg::CNT_HOLD;
        cmd.fin_code = dcbe_pkg::ST_RUNNING;
        cmd.sel     = sel;
        do_before   = 1'b0;
        bef_nl_mode = M_S_NEWLINE;
        bef_in_mode = M_S_INSIDE;
        bef_err     = dcbe_pkg::ST_SHORT_SL;

        if (eff_mode != M_DONE && !i_status.is_cr) begin
            unique case (eff_mode)
                M_START: begin
                    if (i_status.is_slash) begin
                        n_mode = M_START2;
                    end else if (!i_status.is_ws) begin
                        cmd.fin = 1'b1;
                        cmd.fin_code = dcbe_pkg::ST_NO_START;
                    end
                end
                M_START2: begin
                    if (i_status.is_star) begin
                        n_mode = M_M_START;
                    end else if (i_status.is_slash) begin
                        n_mode = M_S_START;
                    end else begin
                        cmd.fin = 1'b1;
                        cmd.fin_code = dcbe_pkg::ST_UNKNOWN;
                    end
                end
                M_S_START: begin
                    if (i_status.is_ws) begin
                        cmd.base_op = dcbe_pkg::CNT_INC;
                    end else begin
                        cmd.emit_char = 1'b1;
                        n_mode = M_S_INSIDE;
                    end
                end
                M_S_INSIDE, M_M_INSIDE: begin
                    if (i_status.is_nl) begin
                        cmd.line_op  = dcbe_pkg::CNT_CLR;
                        cmd.blank_op = dcbe_pkg::CNT_ONE;
                        n_mode = (eff_mode == M_S_INSIDE) ? M_S_NEWLINE : M_M_NEWLINE;
                    end else begin
                        cmd.emit_char = 1'b1;
                    end
                end
                M_S_NEWLINE: begin
                    if (i_status.is_slash) begin
                        n_mode = M_S_HALF;
                    end else if (!i_status.is_ws) begin
                        cmd.fin = 1'b1;
                        cmd.fin_code = dcbe_pkg::ST_DONE;
                    end
                end
                M_S_HALF: begin
                    if (i_status.is_slash) begin
                        n_mode = M_S_BEFORE;
                    end else begin
                        cmd.fin = 1'b1;
                        cmd.fin_code = dcbe_pkg::ST_DONE;
                    end
                end
                M_S_BEFORE: begin
                    do_before = 1'b1;
                end
                M_M_START: begin
                    if (i_status.is_star) begin
                        cmd.base_op = dcbe_pkg::CNT_CLR;
                    end else if (i_status.is_ws) begin
                        cmd.base_op = dcbe_pkg::CNT_INC;
                    end else begin
                        cmd.emit_char = 1'b1;
                        n_mode = M_M_INSIDE;
                    end
                end
                M_M_NEWLINE: begin
                    if (i_status.is_star) begin
                        n_mode = M_M_BEFORE;
                    end else if (!i_status.is_ws) begin
                        cmd.fin = 1'b1;
                        cmd.fin_code = dcbe_pkg::ST_DONE;
                    end
                end
                M_M_BEFORE: begin
                    // A slash right after the star closes the block comment.
                    if (i_status.line_zero && i_status.is_slash) begin
                        cmd.fin = 1'b1;
                        cmd.fin_code = dcbe_pkg::ST_DONE;
                    end else begin
                        do_before   = 1'b1;
                        bef_nl_mode = M_M_NEWLINE;
                        bef_in_mode = M_M_INSIDE;
                        bef_err     = dcbe_pkg::ST_SHORT_STAR;
                    end
                end
                default: begin
                    cmd.fin = 1'b1;
                    cmd.fin_code = dcbe_pkg::ST_DONE;
                end
            endcase

            // Body line after a marker: count indentation, hold blank lines;
            // on text flush them; fail under base, else space-pad, pass char.
            if (do_before) begin
                if (i_status.is_sp) begin
                    cmd.line_op = dcbe_pkg::CNT_INC;
                end else if (i_status.is_nl) begin
                    cmd.blank_op = dcbe_pkg::CNT_INC;
                    cmd.line_op  = dcbe_pkg::CNT_CLR;
                    n_mode = bef_nl_mode;
                end else if (!i_status.is_ws) begin
                    cmd.emit_blanks = 1'b1;
                    cmd.blank_op    = dcbe_pkg::CNT_CLR;
                    if (i_status.line_lt_base) begin
                        cmd.fin = 1'b1;
                        cmd.fin_code = bef_err;
                    end else begin
                        cmd.emit_spaces = 1'b1;
                        cmd.emit_char   = 1'b1;
                        cmd.line_op     = dcbe_pkg::CNT_CLR;
                        n_mode = bef_in_mode;
                    end
                end
            end
        end

        if (cmd.fin) begin
            n_mode = M_DONE;
        end
        cmd.take     = take;
        cmd.load_out = load_out;
        cmd.last     = emit_last;
    end

    assign o_cmd   = cmd;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_START;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_mode <= n_mode;
            end
            if (take) begin
                r_busy <= 1'b1;
            end else if (load_out && emit_last) begin
                r_busy <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `DCBE_ASSERT_NOW(a_take_only_at_job_end, i_clk, i_rst_n, take && r_busy, load_out && emit_last, "request taken while job still has results")
    `DCBE_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, load_out && emit_last && !take, !r_busy, "sequencer busy after last result")
    `DCBE_ASSERT_NOW(a_empty_only_for_empty_job, i_clk, i_rst_n, load_out && sel == dcbe_pkg::SEL_NONE, i_status.nl_zero && i_status.sp_zero && !i_status.job_ch, "empty result from a job with pending output")
    `DCBE_ASSERT_NOW(a_done_is_silent, i_clk, i_rst_n, take && r_mode == M_DONE && !i_begin_req, !cmd.emit_char && !cmd.emit_spaces && !cmd.emit_blanks && !cmd.fin, "finished parser acted on input")

endmodule

// ----- design/doc_comment_body_extractor.sv -----
// Top level of the doc comment body extractor.
// Depends on dcbe_pkg, dcbe_ctrl and dcbe_dp.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_valid / o_ready) takes one source character per request:
//   i_ch is the codepoint, i_begin_req restarts the parser before that
//   character is handled. Output channel (o_valid / i_ready) delivers the
//   results of each request in order: o_out_char with o_has_char, the status
//   after the request (o_status) and o_last on the final result of it.
//   A request that emits nothing still yields one result with o_has_char low.
// Results and throughput:
//   A request's first result passes the dcbe_dp job registers, then the output
//   register. The emission sequencer in dcbe_ctrl yields one result for plain
//   text, 1 + held blank lines + extra indentation spaces for the first
//   character of a continuation line. The next request is accepted in the same
//   cycle as the previous one's last result moves into the output register,
//   so plain text runs at one per cycle while i_ready stays high.
// Reset:
//   Synchronous, active low. Parser returns to the start state, counters and
//   status clear, no result is pending.
// Stalls:
//   When i_ready is low the output register holds its result; the pending job
//   waits and o_ready drops once the job still has results left to send.
module doc_comment_body_extractor #(
    parameter int MAX_INDENT      = dcbe_pkg::DEF_MAX_INDENT,
    parameter int MAX_BLANK_LINES = dcbe_pkg::DEF_MAX_BLANK_LINES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dcbe_pkg::CH_W-1:0]   i_ch,
    input  logic                        i_begin_req,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [dcbe_pkg::CH_W-1:0]   o_out_char,
    output logic                        o_has_char,
    output logic [dcbe_pkg::ST_W-1:0]   o_status,
    output logic                        o_last
);

    // Command and status between controller and datapath.
    dcbe_pkg::t_dp_cmd    dp_cmd;
    dcbe_pkg::t_dp_status dp_status;

    dcbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_begin_req (i_begin_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    dcbe_dp #(
        .MAX_INDENT      (MAX_INDENT),
        .MAX_BLANK_LINES (MAX_BLANK_LINES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ch         (i_ch),
        .i_begin_req  (i_begin_req),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_out_char   (o_out_char),
        .o_has_char   (o_has_char),
        .o_out_status (o_status),
        .o_last       (o_last)
    );

endmodule
